// ===== design/bf3_pkg.sv =====
// Shared constants, types and the reciprocal table for the 3x3 box filter.
`timescale 1ns / 1ps

package bf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int SAMPLE_W   = 16;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int RESET_WIDTH  = 256;
  localparam int RESET_HEIGHT = 256;

  // column sum of up to 3 samples, window sum of up to 9
  localparam int COL_SUM_W = SAMPLE_W + 2;
  localparam int SUM_W     = SAMPLE_W + 4;
  localparam int CNT_W     = 4;

  // quotient = (sum * recip) >> RECIP_SHIFT, exact for sum < 2^SUM_W
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  localparam int CREDIT_W   = FIFO_CNT_W + 1;
  localparam int STAGES     = 4;
  localparam int FLIGHT_W   = $clog2(STAGES + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_t;

  // per-item control that travels down the pipe
  typedef struct packed {
    logic emit;
    logic tv;
    logic bv;
    logic last_row;
    logic row_end;
    logic col_ge1;
    logic col_ge2;
  } ctl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                row_end;
    logic                frame_end;
  } result_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    m = '0;
    case (cnt)
      4'd2:    m = 24'd8388608;
      4'd3:    m = 24'd5592406;
      4'd4:    m = 24'd4194304;
      4'd6:    m = 24'd2796203;
      4'd9:    m = 24'd1864136;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/box_filter_3x3_unit.sv =====
// Streaming 3x3 box filter with edge clipping, pipelined, with output queue.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+--------------------------------------
// in_      | input     | in_valid / in_stall | in_sample
// out_     | output    | out_valid/out_stall | out_average, out_row_end, out_frame_end
// cfg_     | input     | cfg_we              | cfg_addr, cfg_data
//
// Takes one sample beat per clock while in_stall is low. A beat passes four
// register stages (line store read, column sum, window sum and reciprocal pick,
// multiply) and lands in a 16-entry result queue. The last beat of a row can
// yield two results; the queue soaks that up, and in_stall rises only when
// queue fill plus beats in flight could overflow it.
// Reset (rst_n low, synchronous) empties the pipe and queue, zeroes positions
// and loads width and height 256. Line stores are not cleared.
// out_stall freezes the queue head only; the pipe keeps running on credit.

module box_filter_3x3_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bf3_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bf3_pkg::SAMPLE_W-1:0]   out_average,
  output logic                           out_row_end,
  output logic                           out_frame_end,
  input  logic                           cfg_we,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------- config
  logic [bf3_pkg::WIDTH_W-1:0]  width_cfg_r;
  logic [bf3_pkg::HEIGHT_W-1:0] height_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= bf3_pkg::WIDTH_W'(bf3_pkg::RESET_WIDTH);
      height_cfg_r <= bf3_pkg::HEIGHT_W'(bf3_pkg::RESET_HEIGHT);
    end else if (cfg_we) begin
      unique case (bf3_pkg::cfg_idx_t'(cfg_addr))
        bf3_pkg::CFG_IMAGE_WIDTH:  width_cfg_r  <= cfg_data[bf3_pkg::WIDTH_W-1:0];
        bf3_pkg::CFG_IMAGE_HEIGHT: height_cfg_r <= cfg_data[bf3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the usable range: width 2..MAX_WIDTH, height at least 2.
  logic [bf3_pkg::WIDTH_W-1:0]  w_eff;
  logic [bf3_pkg::HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (width_cfg_r < bf3_pkg::WIDTH_W'(2)) begin
      w_eff = bf3_pkg::WIDTH_W'(2);
    end else if (width_cfg_r > bf3_pkg::WIDTH_W'(bf3_pkg::MAX_WIDTH)) begin
      w_eff = bf3_pkg::WIDTH_W'(bf3_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_cfg_r;
    end
    if (height_cfg_r < bf3_pkg::HEIGHT_W'(2)) begin
      h_eff = bf3_pkg::HEIGHT_W'(2);
    end else begin
      h_eff = height_cfg_r;
    end
  end

  // ------------------------------------------------------ stage 0: position
  logic [bf3_pkg::ADDR_W-1:0]   col_r, col_nxt;
  logic [bf3_pkg::HEIGHT_W-1:0] row_r, row_nxt;
  logic                         pend_r, pend_nxt;
  logic                         in_acc;
  logic [bf3_pkg::WIDTH_W-1:0]  col_inc;
  logic [bf3_pkg::HEIGHT_W:0]   row_inc;
  logic                         frame_last;
  bf3_pkg::ctl_t                ctl_s0;

  assign in_acc  = in_valid && !in_stall;
  assign col_inc = bf3_pkg::WIDTH_W'({1'b0, col_r}) + bf3_pkg::WIDTH_W'(1);
  assign row_inc = {1'b0, row_r} + (bf3_pkg::HEIGHT_W + 1)'(1);

  always_comb begin
    ctl_s0         = '0;
    ctl_s0.row_end = (col_inc >= w_eff);
    ctl_s0.col_ge1 = (col_r != '0);
    ctl_s0.col_ge2 = (col_r[bf3_pkg::ADDR_W-1:1] != '0);
    frame_last     = ctl_s0.row_end && (row_inc >= {1'b0, h_eff});

    // Row r >= 1 emits row r-1; during row 0 the held last row of the
    // previous frame comes out, with no bottom neighbors.
    priority if (row_r != '0) begin
      ctl_s0.emit = 1'b1;
      ctl_s0.tv   = (row_r[bf3_pkg::HEIGHT_W-1:1] != '0);
      ctl_s0.bv   = 1'b1;
    end else if (pend_r) begin
      ctl_s0.emit     = 1'b1;
      ctl_s0.tv       = 1'b1;
      ctl_s0.last_row = 1'b1;
    end else begin
      ctl_s0.emit = 1'b0;
    end

    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (in_acc) begin
      if (ctl_s0.row_end) begin
        col_nxt = '0;
        if (row_r == '0) begin
          pend_nxt = 1'b0;
        end
        if (frame_last) begin
          row_nxt  = '0;
          pend_nxt = 1'b1;
        end else begin
          row_nxt = row_inc[bf3_pkg::HEIGHT_W-1:0];
        end
      end else begin
        col_nxt = col_inc[bf3_pkg::ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  // ----------------------------------------------------------- line stores
  // Lower holds the row above, upper the row above that. Lower is rewritten
  // with the new sample at accept; upper takes lower's old value in the cycle
  // after. Consecutive beats never share a column, so no read/write clash.
  logic [bf3_pkg::SAMPLE_W-1:0] upper_mem [bf3_pkg::MAX_WIDTH];
  logic [bf3_pkg::SAMPLE_W-1:0] lower_mem [bf3_pkg::MAX_WIDTH];
  logic [bf3_pkg::SAMPLE_W-1:0] upper_rd_r;
  logic [bf3_pkg::SAMPLE_W-1:0] lower_rd_r;

  logic                         s1_valid_r;
  bf3_pkg::ctl_t                s1_ctl_r;
  logic [bf3_pkg::ADDR_W-1:0]   s1_addr_r;
  logic [bf3_pkg::SAMPLE_W-1:0] s1_sample_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lower_rd_r         <= lower_mem[col_r];
      lower_mem[col_r]   <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      upper_rd_r <= upper_mem[col_r];
    end
    if (s1_valid_r) begin
      upper_mem[s1_addr_r] <= lower_rd_r;
    end
  end

  // ------------------------------------------------- stage 1: column sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r    <= ctl_s0;
      s1_addr_r   <= col_r;
      s1_sample_r <= in_sample;
    end
  end

  logic [bf3_pkg::COL_SUM_W-1:0] cur_col;

  assign cur_col =
      (s1_ctl_r.tv ? bf3_pkg::COL_SUM_W'(upper_rd_r) : '0)
    + bf3_pkg::COL_SUM_W'(lower_rd_r)
    + (s1_ctl_r.bv ? bf3_pkg::COL_SUM_W'(s1_sample_r) : '0);

  // Window: column sums of the two previous columns of the same row.
  logic [bf3_pkg::COL_SUM_W-1:0] win_p1_r;
  logic [bf3_pkg::COL_SUM_W-1:0] win_p2_r;

  logic                          s2_valid_r;
  bf3_pkg::ctl_t                 s2_ctl_r;
  logic [bf3_pkg::COL_SUM_W-1:0] s2_cur_r;
  logic [bf3_pkg::COL_SUM_W-1:0] s2_p1_r;
  logic [bf3_pkg::COL_SUM_W-1:0] s2_p2_r;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win_p1_r <= cur_col;
      win_p2_r <= win_p1_r;
      s2_ctl_r <= s1_ctl_r;
      s2_cur_r <= cur_col;
      s2_p1_r  <= win_p1_r;
      s2_p2_r  <= win_p2_r;
    end
  end

  // ------------------------------------------ stage 2: window sums, counts
  // Result A is the pixel one column back; result B, on a row end, is the
  // last pixel of the row.
  logic [1:0]                rows;
  logic [bf3_pkg::CNT_W-1:0] cnt_a;
  logic [bf3_pkg::CNT_W-1:0] cnt_b;
  logic [bf3_pkg::SUM_W-1:0] sum_a;
  logic [bf3_pkg::SUM_W-1:0] sum_b;

  always_comb begin
    rows  = 2'd1 + 2'(s2_ctl_r.tv) + 2'(s2_ctl_r.bv);
    cnt_a = bf3_pkg::CNT_W'(rows) * (s2_ctl_r.col_ge2 ? bf3_pkg::CNT_W'(3)
                                                      : bf3_pkg::CNT_W'(2));
    cnt_b = bf3_pkg::CNT_W'(rows) * (s2_ctl_r.col_ge1 ? bf3_pkg::CNT_W'(2)
                                                      : bf3_pkg::CNT_W'(1));
    sum_a = (s2_ctl_r.col_ge2 ? bf3_pkg::SUM_W'(s2_p2_r) : '0)
          + bf3_pkg::SUM_W'(s2_p1_r) + bf3_pkg::SUM_W'(s2_cur_r);
    sum_b = (s2_ctl_r.col_ge1 ? bf3_pkg::SUM_W'(s2_p1_r) : '0)
          + bf3_pkg::SUM_W'(s2_cur_r);
  end

  logic                        s3_va_r;
  logic                        s3_vb_r;
  logic                        s3_last_r;
  logic [bf3_pkg::SUM_W-1:0]   s3_sum_a_r;
  logic [bf3_pkg::SUM_W-1:0]   s3_sum_b_r;
  logic [bf3_pkg::RECIP_W-1:0] s3_rcp_a_r;
  logic [bf3_pkg::RECIP_W-1:0] s3_rcp_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_va_r    <= 1'b0;
      s3_vb_r    <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
      s3_va_r    <= s2_valid_r && s2_ctl_r.emit && s2_ctl_r.col_ge1;
      s3_vb_r    <= s2_valid_r && s2_ctl_r.emit && s2_ctl_r.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      s3_last_r  <= s2_ctl_r.last_row;
      s3_sum_a_r <= sum_a;
      s3_sum_b_r <= sum_b;
      s3_rcp_a_r <= bf3_pkg::recip(cnt_a);
      s3_rcp_b_r <= bf3_pkg::recip(cnt_b);
    end
  end

  // --------------------------------------------- stage 3: reciprocal mult
  logic                       s3_valid_r;
  logic                       s4_va_r;
  logic                       s4_vb_r;
  logic                       s4_last_r;
  logic [bf3_pkg::PROD_W-1:0] s4_prod_a_r;
  logic [bf3_pkg::PROD_W-1:0] s4_prod_b_r;
  logic                       s4_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s4_va_r    <= 1'b0;
      s4_vb_r    <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s4_va_r    <= s3_va_r;
      s4_vb_r    <= s3_vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_va_r || s3_vb_r) begin
      s4_last_r   <= s3_last_r;
      s4_prod_a_r <= bf3_pkg::PROD_W'(s3_sum_a_r) * bf3_pkg::PROD_W'(s3_rcp_a_r);
      s4_prod_b_r <= bf3_pkg::PROD_W'(s3_sum_b_r) * bf3_pkg::PROD_W'(s3_rcp_b_r);
    end
  end

  // ---------------------------------------------------------- result queue
  // Up to two pushes a clock (A then B), one pop.
  bf3_pkg::result_t                fifo_mem [bf3_pkg::FIFO_DEPTH];
  logic [bf3_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [bf3_pkg::FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [bf3_pkg::FIFO_CNT_W-1:0]  fill_r, fill_nxt;
  logic [bf3_pkg::FIFO_PTR_W-1:0]  wr_ptr_b;
  bf3_pkg::result_t                res_a;
  bf3_pkg::result_t                res_b;
  logic                            pop;
  logic [1:0]                      push_n;

  assign res_a.average   = s4_prod_a_r[bf3_pkg::RECIP_SHIFT +: bf3_pkg::SAMPLE_W];
  assign res_a.row_end   = 1'b0;
  assign res_a.frame_end = 1'b0;
  assign res_b.average   = s4_prod_b_r[bf3_pkg::RECIP_SHIFT +: bf3_pkg::SAMPLE_W];
  assign res_b.row_end   = 1'b1;
  assign res_b.frame_end = s4_last_r;

  assign wr_ptr_b = wr_ptr_r + bf3_pkg::FIFO_PTR_W'(s4_va_r);
  assign push_n   = 2'(s4_va_r) + 2'(s4_vb_r);
  assign pop      = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + bf3_pkg::FIFO_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + bf3_pkg::FIFO_PTR_W'(pop);
    fill_nxt   = fill_r + bf3_pkg::FIFO_CNT_W'(push_n) - bf3_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (s4_va_r) begin
      fifo_mem[wr_ptr_r] <= res_a;
    end
    if (s4_vb_r) begin
      fifo_mem[wr_ptr_b] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign out_valid     = (fill_r != '0);
  assign out_average   = fifo_mem[rd_ptr_r].average;
  assign out_row_end   = fifo_mem[rd_ptr_r].row_end;
  assign out_frame_end = fifo_mem[rd_ptr_r].frame_end;

  // Credit: every beat in flight may still bring two results; accept a new
  // beat only if its two results fit as well.
  logic [bf3_pkg::FLIGHT_W-1:0] in_flight;
  logic [bf3_pkg::CREDIT_W-1:0] need;

  assign in_flight = bf3_pkg::FLIGHT_W'(s1_valid_r) + bf3_pkg::FLIGHT_W'(s2_valid_r)
                   + bf3_pkg::FLIGHT_W'(s3_valid_r) + bf3_pkg::FLIGHT_W'(s4_valid_r);
  assign need      = bf3_pkg::CREDIT_W'(fill_r)
                   + bf3_pkg::CREDIT_W'({in_flight, 1'b0})
                   + bf3_pkg::CREDIT_W'(2);
  assign in_stall  = (need > bf3_pkg::CREDIT_W'(bf3_pkg::FIFO_DEPTH));

endmodule

// ===== design/bf3_checker.sv =====
// Port-level checks for the 3x3 box filter, bound to the top level.
`timescale 1ns / 1ps

module bf3_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bf3_pkg::SAMPLE_W-1:0]   out_average,
  input logic                           out_row_end,
  input logic                           out_frame_end
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_average) && $stable(out_row_end)
                              && $stable(out_frame_end))
    else $error("result payload changed while stalled");

  // a frame always ends on a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame_end without row_end");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind box_filter_3x3_unit bf3_checker u_bf3_checker (.*);

// ===== tb/sv/tb_box_filter_3x3_unit.sv =====
// Self-checking testbench for the streaming 3x3 box filter unit.
`timescale 1ns / 1ps

module tb_box_filter_3x3_unit;
  import bf3_pkg::*;

  // columns written by the priming frame; later runs stay inside these columns
  localparam int PRIME_W = 12;

  // Scoreboard: a cycle-free model of the filter that turns each accepted
  // sample beat into the means it releases, plus the queue those wait in.
  class box_mean_sb;
    logic [SAMPLE_W-1:0] upper_row [MAX_WIDTH];
    logic [SAMPLE_W-1:0] lower_row [MAX_WIDTH];
    // win[0] = column two back, win[1] = previous column, win[2] = current;
    // row index 0 = top, 1 = middle, 2 = bottom
    logic [SAMPLE_W-1:0] win [3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    bit tail_pending;
    logic [WIDTH_W-1:0] width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    result_t pending_means[$];
    int mismatches;

    function new();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++)
          win[k][j] = '0;
      col_pos = 0;
      row_pos = 0;
      tail_pending = 1'b0;
      width_reg = WIDTH_W'(RESET_WIDTH);
      height_reg = HEIGHT_W'(RESET_HEIGHT);
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_IMAGE_WIDTH)
        width_reg = val[WIDTH_W-1:0];
      else if (idx == CFG_IMAGE_HEIGHT)
        height_reg = val[HEIGHT_W-1:0];
    endfunction

    function int outstanding();
      return pending_means.size();
    endfunction

    // truncated mean over the selected columns and rows of the window
    function logic [SAMPLE_W-1:0] box_mean(bit use_far, bit use_near, bit top_ok, bit bot_ok);
      int unsigned total;
      int unsigned n;
      total = 0;
      n = 0;
      for (int k = 0; k < 3; k++) begin
        if (k == 2 || (k == 1 && use_near) || (k == 0 && use_far)) begin
          for (int j = 0; j < 3; j++) begin
            if (j == 1 || (j == 0 && top_ok) || (j == 2 && bot_ok)) begin
              total += win[k][j];
              n++;
            end
          end
        end
      end
      return (n != 0) ? SAMPLE_W'(total / n) : '0;
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s);
      int unsigned w, h, c, r;
      bit row_end, frame_last, emit, top_ok, bot_ok, last_row;
      result_t res;
      w = width_reg;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = height_reg;
      if (h < 2) h = 2;
      c = col_pos;
      if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
      r = row_pos;

      win[2][0] = upper_row[c];
      win[2][1] = lower_row[c];
      win[2][2] = s;
      upper_row[c] = win[2][1];
      lower_row[c] = s;

      row_end = (c + 1) >= w;
      frame_last = row_end && (r + 1) >= h;
      emit = 1'b0;
      top_ok = 1'b0;
      bot_ok = 1'b0;
      last_row = 1'b0;
      if (r >= 1) begin
        emit = 1'b1;
        top_ok = (r >= 2);
        bot_ok = 1'b1;
      end else if (tail_pending) begin
        // row 0 of a new frame drains the last row of the previous one
        emit = 1'b1;
        top_ok = 1'b1;
        last_row = 1'b1;
      end

      if (emit && c >= 1) begin
        res.average = box_mean(c >= 2, 1'b1, top_ok, bot_ok);
        res.row_end = 1'b0;
        res.frame_end = 1'b0;
        pending_means.push_back(res);
      end
      if (emit && row_end) begin
        res.average = box_mean(1'b0, c >= 1, top_ok, bot_ok);
        res.row_end = 1'b1;
        res.frame_end = last_row;
        pending_means.push_back(res);
      end

      for (int j = 0; j < 3; j++) begin
        win[0][j] = win[1][j];
        win[1][j] = win[2][j];
      end

      if (row_end) begin
        col_pos = 0;
        if (r == 0) tail_pending = 1'b0;
        if (frame_last) begin
          row_pos = 0;
          tail_pending = 1'b1;
        end else begin
          row_pos = (r + 1) & 32'hFFFF;
        end
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_mean(result_t got);
      result_t want;
      if (pending_means.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result beat with nothing expected: avg %h row_end %b frame_end %b",
                   $time, got.average, got.row_end, got.frame_end);
        mismatches++;
        return;
      end
      want = pending_means.pop_front();
      if (got.average !== want.average || got.row_end !== want.row_end ||
          got.frame_end !== want.frame_end) begin
        if (mismatches < 10)
          $display("%0t: mismatch avg exp %h got %h, row_end exp %b got %b, frame_end exp %b got %b",
                   $time, want.average, got.average, want.row_end, got.row_end,
                   want.frame_end, got.frame_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SAMPLE_W-1:0]   out_average;
  logic                  out_row_end;
  logic                  out_frame_end;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_mean_sb sb = new();

  // idle rates in percent per cycle; set by the stimulus, read by both sides
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long receiver hold-off: stimulus bumps hold_trig, receiver counts it out
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;

  box_filter_3x3_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_average   (out_average),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: stall decided at the falling edge, so it is stable at the
  // rising edge where the beat is taken.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_trig != hold_seen) begin
      // long hold-off so the result queue fills and in_stall must rise
      hold_seen = hold_trig;
      hold_left = 59;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result beats are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.average = out_average;
      got.row_end = out_row_end;
      got.frame_end = out_frame_end;
      sb.check_mean(got);
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_pixel();
    // bias toward the extremes so saturated sums and all-zero windows show up
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offer one sample beat; called and returns at a falling edge. Valid is
  // only dropped when the sender chooses to idle, never toggled within a step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_sample = SAMPLE_W'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_sample(s);
    @(negedge clk);
  endtask

  // Wait for every expected result, then give the pipe time to finish beats
  // that release nothing (row 0 of the first frame, the first beat of a row).
  task automatic drain();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int rand_count;
    int burst;
    bit held;
    rand_count = 0;
    held = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 78;

    // Priming frame, PRIME_W wide and two rows high (0 clamps to height 2),
    // so both line stores hold real data in every column used later.
    write_reg(CFG_IMAGE_WIDTH, 16'(PRIME_W));
    write_reg(CFG_IMAGE_HEIGHT, 16'd0);
    for (int i = 0; i < 2 * PRIME_W; i++)
      send_sample(pick_pixel());
    drain();

    // 2x2 frame: every output is a corner; also flushes the primed last row
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    send_sample('1);
    send_sample('0);
    send_sample('1);
    send_sample('1);
    drain();

    // 3x3 all-max: corner, edge and full nine-sample means at the top value
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    repeat (9) send_sample('1);
    drain();

    // Shrink mid-frame: column and row already past the new bounds
    write_reg(CFG_IMAGE_WIDTH, 16'd5);
    write_reg(CFG_IMAGE_HEIGHT, 16'd5);
    repeat (13) send_sample(pick_pixel());
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    repeat (3) send_sample(pick_pixel());
    drain();

    // Width above the limit clamps to MAX_WIDTH; a short run stays inside
    // the primed columns, then a narrower width ends the row at once.
    write_reg(CFG_IMAGE_WIDTH, 16'd2047);
    write_reg(CFG_IMAGE_HEIGHT, 16'd4);
    repeat (6) send_sample(pick_pixel());
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'd4);
    send_sample(pick_pixel());

    // Random bursts with fresh sizes between them; bursts often stop
    // mid-frame so the size changes land at every position.
    while (rand_count < 84) begin
      if (rand_count >= 56) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rand_count >= 28) begin
        send_idle_pct = 78;
        recv_idle_pct = 31;
      end
      drain();
      if ($urandom_range(0, 1)) begin
        if ($urandom_range(0, 9) == 0)
          write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(0, 1)));
        else
          write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(2, 9)));
      end
      if ($urandom_range(0, 1)) begin
        if ($urandom_range(0, 9) == 0)
          write_reg(CFG_IMAGE_HEIGHT,
                    ($urandom_range(0, 1)) ? 16'hFFFF : 16'($urandom_range(0, 1)));
        else
          write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(2, 5)));
      end
      burst = $urandom_range(4, 20);
      if (rand_count >= 56 && !held) begin
        // sender keeps offering while the receiver holds off
        held = 1'b1;
        hold_trig = hold_trig + 1;
        burst = 30;
      end
      repeat (burst) begin
        send_sample(pick_pixel());
        rand_count++;
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
